// ----- hw/rtl/flowsc_pkg.sv -----
package flowsc_pkg;

  // Field and datapath widths
  localparam int SUM_W     = 32;
  localparam int PIX_W     = 8;
  localparam int SCALE_W   = 8;
  localparam int DET_W     = 64;
  localparam int PROD_W    = DET_W + SCALE_W;
  localparam int DIV_STEPS = 8;
  localparam int Q_W       = DIV_STEPS + 1;

  // Constants of the flow mapping
  localparam logic [Q_W-1:0]     SAT_Q     = 9'd256;
  localparam logic [PIX_W-1:0]   FLOW_MID  = 8'd127;
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd64;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_xx;
    logic signed [SUM_W-1:0] sum_xy;
    logic signed [SUM_W-1:0] sum_yy;
    logic signed [SUM_W-1:0] sum_dx;
    logic signed [SUM_W-1:0] sum_dy;
  } flowsc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] flow_x;
    logic [PIX_W-1:0] flow_y;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } flowsc_out_t;

  // Per-pixel flags that ride alongside the quotient pipeline
  typedef struct packed {
    logic det_ok;
    logic neg_x;
    logic neg_y;
  } flowsc_side_t;

endpackage

// ----- hw/rtl/flowsc_qdiv.sv -----
module flowsc_qdiv import flowsc_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [PROD_W-1:0] p_in,
  input  logic [DET_W-1:0]  det_in,
  output logic [Q_W-1:0]    q_out
);

  logic [PROD_W-1:0]    rem_r [0:DIV_STEPS];
  logic [DET_W-1:0]     det_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [0:DIV_STEPS];
  logic                 sat_r [0:DIV_STEPS];

  // Check saturation: quotient of 256 or more clamps
  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r[0] <= (p_in >= {det_in, {DIV_STEPS{1'b0}}});
      rem_r[0] <= p_in;
      det_r[0] <= det_in;
      q_r[0]   <= '0;
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int B = DIV_STEPS - k;
    logic [PROD_W-1:0] dv;
    logic              take;
    assign dv   = PROD_W'(det_r[k-1]) << B;
    assign take = (rem_r[k-1] >= dv);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= take ? (rem_r[k-1] - dv) : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (DIV_STEPS'(take) << B);
        det_r[k] <= det_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  assign q_out = sat_r[DIV_STEPS] ? SAT_Q : {1'b0, q_r[DIV_STEPS]};

endmodule

// ----- hw/rtl/flowsc_color.sv -----
module flowsc_color import flowsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         vld_in,
  input  flowsc_side_t side_in,
  input  logic [Q_W-1:0] qx,
  input  logic [Q_W-1:0] qy,
  output logic         out_valid,
  output flowsc_out_t  out_data
);

  function automatic logic [PIX_W-1:0] to_pix(input logic neg, input logic [Q_W-1:0] m);
    logic signed [Q_W+1:0] v;
    v = neg ? ((Q_W+2)'(FLOW_MID) - (Q_W+2)'(m)) : ((Q_W+2)'(FLOW_MID) + (Q_W+2)'(m));
    if (v < 0) return '0;
    else if (v > 255) return '1;
    else return PIX_W'(v);
  endfunction

  logic [PIX_W-1:0] x, y;
  logic [PIX_W:0]   r, g, b, half_y;
  logic             valid_r;
  flowsc_out_t      data_r;

  // Offset, clamp, and fall back to zero flow unless the determinant is above 1
  always_comb begin
    x = side_in.det_ok ? to_pix(side_in.neg_x, qx) : FLOW_MID;
    y = side_in.det_ok ? to_pix(side_in.neg_y, qy) : FLOW_MID;
  end

  // Map by quadrant to a pseudo-color
  always_comb begin
    half_y = ({1'b0, FLOW_MID} - {1'b0, y}) >> 1;
    r = '0;
    g = '0;
    b = '0;
    if (x > FLOW_MID) begin
      if (y <= FLOW_MID) begin
        r = {1'b0, x} - {1'b0, FLOW_MID} + half_y;
        g = half_y;
      end else begin
        r = {1'b0, x} - {1'b0, FLOW_MID};
        b = {1'b0, y} - {1'b0, FLOW_MID};
      end
    end else begin
      if (y <= FLOW_MID) begin
        r = half_y;
        g = {1'b0, FLOW_MID} - {1'b0, x} + half_y;
      end else begin
        g = {1'b0, FLOW_MID} + 9'd1 - {1'b0, x};
        b = {1'b0, y} - {1'b0, FLOW_MID};
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r.flow_x <= x;
      data_r.flow_y <= y;
      data_r.red    <= r[PIX_W-1:0];
      data_r.green  <= g[PIX_W-1:0];
      data_r.blue   <= b[PIX_W-1:0];
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hw/rtl/flow_solve_and_colorize.sv -----
// Lucas-Kanade 2x2 flow solve with pseudo-color output.
// Input channel (in_valid/in_ready/in_data): one pixel's five windowed
// gradient sums per transaction. Output channel (out_valid/out_ready/
// out_data): the offset, clamped flow pair and its quadrant RGB color.
// Configuration: cfg_wr_en/cfg_wr_data write the 8-bit flow scale;
// write it only while no pixel is in flight.
// From input to output transaction the stages are: products, Cramer
// terms, scale multiply in two halves, then one restoring quotient bit per
// stage for a saturation check and eight bits, then the color stage.
// Throughput is one pixel per cycle unless the receiver stalls; the
// whole pipeline advances as one. When the receiver stalls with a result
// waiting, every stage holds and in_ready drops; no transaction is lost or
// repeated, and bubbles keep their place in the pipeline.
// Reset (rst_n, synchronous, active low) clears all stage valid bits and
// sets the flow scale to 64.
module flow_solve_and_colorize import flowsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  flowsc_in_t         in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output flowsc_out_t        out_data,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data
);

  localparam int LAST = 4 + DIV_STEPS + 1;

  logic                 adv;
  logic [SCALE_W-1:0]   scale_r, sc1_r, sc2_r;
  logic                 vld_r [1:LAST];
  flowsc_side_t         side_r [2:LAST];
  flowsc_side_t         side_nxt;

  logic signed [DET_W-1:0] xxyy_r, xyxy_r, yydx_r, xydy_r, xxdy_r, xydx_r;
  logic signed [DET_W:0]   det_nxt, nx_nxt, ny_nxt;
  logic [DET_W:0]          magx_nxt, magy_nxt;
  logic [DET_W-1:0]        det2_r, det3_r, det4_r, magx_r, magy_r;
  logic [SUM_W+SCALE_W-1:0] pxl_r, pxh_r, pyl_r, pyh_r;
  logic [PROD_W-1:0]       px_r, py_r;
  logic [Q_W-1:0]          qx, qy;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int i = 2; i <= LAST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: the six gradient products
  always_ff @(posedge clk) begin
    if (adv) begin
      xxyy_r <= in_data.sum_xx * in_data.sum_yy;
      xyxy_r <= in_data.sum_xy * in_data.sum_xy;
      yydx_r <= in_data.sum_yy * in_data.sum_dx;
      xydy_r <= in_data.sum_xy * in_data.sum_dy;
      xxdy_r <= in_data.sum_xx * in_data.sum_dy;
      xydx_r <= in_data.sum_xy * in_data.sum_dx;
      sc1_r  <= scale_r;
    end
  end

  // Stage 2: determinant, numerators and their magnitudes
  always_comb begin
    det_nxt  = (DET_W+1)'(xxyy_r) - (DET_W+1)'(xyxy_r);
    nx_nxt   = (DET_W+1)'(yydx_r) - (DET_W+1)'(xydy_r);
    ny_nxt   = (DET_W+1)'(xxdy_r) - (DET_W+1)'(xydx_r);
    magx_nxt = nx_nxt[DET_W] ? -nx_nxt : nx_nxt;
    magy_nxt = ny_nxt[DET_W] ? -ny_nxt : ny_nxt;
    side_nxt.det_ok = (det_nxt > 1);
    side_nxt.neg_x  = nx_nxt[DET_W];
    side_nxt.neg_y  = ny_nxt[DET_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det2_r    <= det_nxt[DET_W-1:0];
      magx_r    <= magx_nxt[DET_W-1:0];
      magy_r    <= magy_nxt[DET_W-1:0];
      side_r[2] <= side_nxt;
      sc2_r     <= sc1_r;
    end
  end

  // Stage 3: scale times magnitude, in two 32-bit halves
  always_ff @(posedge clk) begin
    if (adv) begin
      pxl_r  <= (SUM_W+SCALE_W)'(sc2_r) * (SUM_W+SCALE_W)'(magx_r[SUM_W-1:0]);
      pxh_r  <= (SUM_W+SCALE_W)'(sc2_r) * (SUM_W+SCALE_W)'(magx_r[DET_W-1:SUM_W]);
      pyl_r  <= (SUM_W+SCALE_W)'(sc2_r) * (SUM_W+SCALE_W)'(magy_r[SUM_W-1:0]);
      pyh_r  <= (SUM_W+SCALE_W)'(sc2_r) * (SUM_W+SCALE_W)'(magy_r[DET_W-1:SUM_W]);
      det3_r <= det2_r;
    end
  end

  // Stage 4: combine the halves
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= (PROD_W'(pxh_r) << SUM_W) + PROD_W'(pxl_r);
      py_r   <= (PROD_W'(pyh_r) << SUM_W) + PROD_W'(pyl_r);
      det4_r <= det3_r;
    end
  end

  // Delay flags alongside the quotient stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 3; i <= LAST; i++) side_r[i] <= side_r[i-1];
    end
  end

  flowsc_qdiv u_qdiv_x (
    .clk    (clk),
    .adv    (adv),
    .p_in   (px_r),
    .det_in (det4_r),
    .q_out  (qx)
  );

  flowsc_qdiv u_qdiv_y (
    .clk    (clk),
    .adv    (adv),
    .p_in   (py_r),
    .det_in (det4_r),
    .q_out  (qy)
  );

  flowsc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_in    (vld_r[LAST]),
    .side_in   (side_r[LAST]),
    .qx        (qx),
    .qy        (qy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A stalled pipeline keeps its first stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r[1]))
    else $error("stage valid changed during stall");

  // Quadrant colors never light all three channels
  a_color_one_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red == 0 || out_data.green == 0 || out_data.blue == 0))
    else $error("all color channels nonzero");

  // Zero flow maps to black
  a_zero_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.flow_x == FLOW_MID && out_data.flow_y == FLOW_MID) |->
    (out_data.red == 0 && out_data.green == 0 && out_data.blue == 0))
    else $error("zero flow not black");

endmodule
